// File: rtl/uesf_pkg.sv
// shared types and constants for the ultrasonic echo scheduler filter
// no dependencies; imported by the core, by both checkers and by the test
`default_nettype none

package uesf_pkg;

	// request codes
	localparam logic [1:0] REQ_ADVANCE = 2'd0;
	localparam logic [1:0] REQ_PING    = 2'd1;
	localparam logic [1:0] REQ_ECHO    = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_ECHO_MIN     = 2'd0;
	localparam logic [1:0] REG_ECHO_MAX     = 2'd1;
	localparam logic [1:0] REG_INVALID_HOLD = 2'd2;
	localparam logic [1:0] REG_ENABLE_MASK  = 2'd3;

	// configuration reset values
	localparam logic [15:0] ECHO_MIN_RST     = 16'd150;
	localparam logic [15:0] ECHO_MAX_RST     = 16'd30000;
	localparam logic [7:0]  INVALID_HOLD_RST = 8'd3;
	localparam logic [9:0]  ENABLE_MASK_RST  = 10'h3ff;

	localparam int unsigned ENABLE_BITS = 10;
	localparam logic [7:0]  COUNT_SAT   = 8'hff;
	localparam logic [1:0]  HIST_DEPTH  = 2'd3;

	// one sensor's filter state, one memory word
	typedef struct packed {
		logic [15:0] filt;
		logic [15:0] h2;
		logic [15:0] h1;
		logic [15:0] h0;
		logic [1:0]  cnt;
		logic [1:0]  head;
		logic [7:0]  inv;
	} sens_entry_t;

	localparam sens_entry_t ENTRY_RST = '{
		filt: ECHO_MAX_RST,
		h2:   ECHO_MAX_RST,
		h1:   ECHO_MAX_RST,
		h0:   ECHO_MAX_RST,
		cnt:  2'd0,
		head: 2'd0,
		inv:  8'd0
	};

endpackage

`default_nettype wire

// File: rtl/ultrasonic_echo_scheduler_filter_core.sv
// ultrasonic echo scheduler with a per-sensor median-of-three filter bank
// a request passes through an address state, in which the state memory is read, and an
//   exec state, in which the entry is updated and written back; busy is high in both, and
//   no new request is taken until the block has returned to idle
// reset: arst_n resets the control and configuration registers and clears the entry valid
//   bits at once; an entry not yet written reads as its reset value, so no clearing pass is needed
// depends on uesf_pkg
`default_nettype none

module ultrasonic_echo_scheduler_filter_core
	import uesf_pkg::*;
#(
	parameter int NUM_SENSORS     = 10,
	parameter int SENSORS_PER_MUX = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [15:0] pulse_width,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [15:0] wr_data,
	output logic             done,
	output logic [3:0]       sensor_index,
	output logic             mux_branch,
	output logic [2:0]       mux_channel,
	output logic [15:0]      filtered_width,
	output logic             sample_valid,
	output logic             filter_reset,
	output logic             none_enabled
);

	localparam int AW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ADDR = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	// per index: {branch bit, channel bits}
	function automatic logic [63:0] mux_tab();
		logic [63:0] t;
		t = '0;
		for (int j = 0; j < 16; j++) begin
			t[j*4 +: 4] = {1'((j / SENSORS_PER_MUX) % 2), 3'((j % SENSORS_PER_MUX) % 8)};
		end
		return t;
	endfunction

	localparam logic [63:0] MUX_TAB = mux_tab();

	function automatic logic [15:0] med3(logic [15:0] a, logic [15:0] b, logic [15:0] c);
		logic [15:0] lo;
		logic [15:0] hi;
		logic [15:0] m;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		m  = (hi < c) ? hi : c;
		return (lo > m) ? lo : m;
	endfunction

	logic [1:0]  state_q;
	logic [1:0]  req_q;
	logic [15:0] pw_q;
	logic [15:0] echo_min_q;
	logic [15:0] echo_max_q;
	logic [7:0]  hold_q;
	logic [9:0]  mask_q;
	logic [3:0]  sched_q;
	logic [3:0]  active_q;
	logic [3:0]  idx_q;
	logic        none_q;

	sens_entry_t mem [NUM_SENSORS];
	logic [NUM_SENSORS-1:0] vld_q;
	sens_entry_t rd_q;
	logic        rd_vld_q;

	logic [15:0] en16;
	logic        found;
	logic [3:0]  found_idx;
	logic [3:0]  idx_addr;

	sens_entry_t cur;
	sens_entry_t nxt;
	logic        is_invalid;
	logic        do_clear;
	logic        do_write;
	logic [7:0]  inv_inc;
	logic [1:0]  head_eff;
	logic [16:0] pair_sum;

	assign busy = (state_q != ST_IDLE);
	assign en16 = {6'd0, mask_q};

	// round-robin search for the next enabled sensor, nearest one wins
	always_comb begin
		logic [4:0] sum;
		found     = 1'b0;
		found_idx = sched_q;
		sum       = '0;
		for (int k = NUM_SENSORS; k >= 1; k--) begin
			sum = 5'(sched_q) + 5'(k);
			if (sum >= 5'(NUM_SENSORS))
				sum = sum - 5'(NUM_SENSORS);
			if (en16[sum[3:0]]) begin
				found     = 1'b1;
				found_idx = sum[3:0];
			end
		end
	end

	always_comb begin
		case (req_q)
			REQ_ADVANCE: idx_addr = found ? found_idx : sched_q;
			REQ_PING:    idx_addr = sched_q;
			default:     idx_addr = active_q;
		endcase
	end

	// filter update on the entry read back from memory
	always_comb begin
		cur        = rd_vld_q ? rd_q : ENTRY_RST;
		nxt        = cur;
		is_invalid = (pw_q <= echo_min_q) || (pw_q >= echo_max_q);
		inv_inc    = (cur.inv == COUNT_SAT) ? cur.inv : cur.inv + 8'd1;
		do_clear   = 1'b0;
		head_eff   = (cur.head >= HIST_DEPTH) ? 2'd0 : cur.head;
		pair_sum   = '0;
		if (is_invalid) begin
			nxt.inv = inv_inc;
			if (inv_inc > hold_q) begin
				do_clear = 1'b1;
				nxt.filt = echo_max_q;
				nxt.h0   = echo_max_q;
				nxt.h1   = echo_max_q;
				nxt.h2   = echo_max_q;
				nxt.cnt  = 2'd0;
				nxt.head = 2'd0;
			end
		end else begin
			nxt.inv = 8'd0;
			case (head_eff)
				2'd0:    nxt.h0 = pw_q;
				2'd1:    nxt.h1 = pw_q;
				default: nxt.h2 = pw_q;
			endcase
			nxt.head = (head_eff == 2'd2) ? 2'd0 : head_eff + 2'd1;
			nxt.cnt  = (cur.cnt < HIST_DEPTH) ? cur.cnt + 2'd1 : cur.cnt;
			pair_sum = 17'(nxt.h0) + 17'(nxt.h1);
			if (nxt.cnt == 2'd1)
				nxt.filt = nxt.h0;
			else if (nxt.cnt == 2'd2)
				nxt.filt = pair_sum[16:1];
			else
				nxt.filt = med3(nxt.h0, nxt.h1, nxt.h2);
		end
	end

	assign do_write = (state_q == ST_EXEC) && (req_q == REQ_ECHO);

	// state memory: registered read in the address state, written back in the exec state for echo requests
	always_ff @(posedge clk) begin
		if (state_q == ST_ADDR)
			rd_q <= mem[idx_addr[AW-1:0]];
		if (do_write)
			mem[idx_q[AW-1:0]] <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (state_q == ST_ADDR)
				rd_vld_q <= vld_q[idx_addr[AW-1:0]];
			if (do_write)
				vld_q[idx_q[AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_min_q <= ECHO_MIN_RST;
			echo_max_q <= ECHO_MAX_RST;
			hold_q     <= INVALID_HOLD_RST;
			mask_q     <= ENABLE_MASK_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ECHO_MIN:     echo_min_q <= wr_data;
				REG_ECHO_MAX:     echo_max_q <= wr_data;
				REG_INVALID_HOLD: hold_q     <= wr_data[7:0];
				REG_ENABLE_MASK:  mask_q     <= wr_data[9:0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			req_q <= req_type;
			pw_q  <= pulse_width;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			sched_q  <= '0;
			active_q <= '0;
			idx_q    <= '0;
			none_q   <= 1'b0;
			done     <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start)
						state_q <= ST_ADDR;
				end
				ST_ADDR: begin
					idx_q  <= idx_addr;
					none_q <= (req_q == REQ_ADVANCE) && !found;
					if (req_q == REQ_ADVANCE && found)
						sched_q <= found_idx;
					if (req_q == REQ_PING)
						active_q <= sched_q;
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result beat registers
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			sensor_index   <= idx_q;
			mux_branch     <= (req_q == REQ_PING) ? MUX_TAB[idx_q*4 + 3] : 1'b0;
			mux_channel    <= (req_q == REQ_PING) ? MUX_TAB[idx_q*4 +: 3] : 3'd0;
			filtered_width <= (req_q == REQ_ECHO) ? nxt.filt : cur.filt;
			sample_valid   <= (req_q == REQ_ECHO) && !is_invalid;
			filter_reset   <= (req_q == REQ_ECHO) && do_clear;
			none_enabled   <= none_q;
		end
	end

endmodule

`default_nettype wire

// File: rtl/uesf_checker.sv
// port-level checks for the echo scheduler filter core
// depends on uesf_pkg; bound to ultrasonic_echo_scheduler_filter_core below
`default_nettype none

module uesf_checker
	import uesf_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic        mux_branch,
	input wire logic [2:0]  mux_channel,
	input wire logic        sample_valid,
	input wire logic        filter_reset,
	input wire logic        none_enabled
);

	// every accepted request is followed by its result beat
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("result beat missing after accepted request");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result beat not at end of busy");

	// flags of different request kinds never mix in one beat
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done && (sample_valid || filter_reset || none_enabled) |->
			!mux_branch && mux_channel == 3'd0 &&
			$countones({sample_valid, filter_reset, none_enabled}) == 1)
		else $error("mixed flags in one result beat");

endmodule

bind ultrasonic_echo_scheduler_filter_core uesf_checker u_uesf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.mux_branch   (mux_branch),
	.mux_channel  (mux_channel),
	.sample_valid (sample_valid),
	.filter_reset (filter_reset),
	.none_enabled (none_enabled)
);

`default_nettype wire

// File: verif/ultrasonic_echo_scheduler_filter_checker.sv
`timescale 1ns / 100ps
// scoreboard for ultrasonic_echo_scheduler_filter_core: follows request and register
// beats, predicts every result beat and compares it field by field
// depends on uesf_pkg
module ultrasonic_echo_scheduler_filter_checker
	import uesf_pkg::*;
#(
	parameter int NUM_SENSORS     = 10,
	parameter int SENSORS_PER_MUX = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [15:0] pulse_width,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [15:0] wr_data,
	input  wire logic        done,
	input  wire logic [3:0]  sensor_index,
	input  wire logic        mux_branch,
	input  wire logic [2:0]  mux_channel,
	input  wire logic [15:0] filtered_width,
	input  wire logic        sample_valid,
	input  wire logic        filter_reset,
	input  wire logic        none_enabled,
	output int               fail_count,
	output int               outstanding
);

	typedef struct packed {
		logic [3:0]  sensor;
		logic        branch;
		logic [2:0]  channel;
		logic [15:0] width;
		logic        valid;
		logic        cleared;
		logic        none;
	} echo_result_t;

	logic [15:0] echo_min;
	logic [15:0] echo_max;
	logic [7:0]  invalid_hold;
	logic [9:0]  enable_mask;

	logic [3:0]  sched_idx;
	logic [3:0]  active_idx;
	logic [15:0] filt_width [NUM_SENSORS];
	logic [15:0] ring [NUM_SENSORS][3];
	logic [1:0]  ring_count [NUM_SENSORS];
	logic [1:0]  ring_head [NUM_SENSORS];
	logic [7:0]  reject_count [NUM_SENSORS];

	echo_result_t expected_results [$];

	initial begin
		fail_count = 0;
		outstanding = 0;
	end

	function automatic void clear_filter(int s);
		filt_width[s] = echo_max;
		ring_count[s] = '0;
		ring_head[s] = '0;
		for (int j = 0; j < 3; j++)
			ring[s][j] = echo_max;
	endfunction

	function automatic logic [15:0] median3(logic [15:0] a, logic [15:0] b, logic [15:0] c);
		logic [15:0] lo;
		logic [15:0] hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (c < lo)
			return lo;
		if (c > hi)
			return hi;
		return c;
	endfunction

	function automatic echo_result_t predict_response(logic [1:0] req, logic [15:0] pw);
		echo_result_t r;
		int           cand;
		int           k;
		int           s;
		int           slot;
		int           q;
		bit           found;
		logic [16:0]  pair_sum;
		r = '0;
		r.sensor = active_idx;
		case (req)
			REQ_ADVANCE: begin
				cand = int'(sched_idx);
				found = 0;
				for (k = 0; k < NUM_SENSORS && !found; k++) begin
					cand = cand + 1;
					if (cand >= NUM_SENSORS)
						cand = 0;
					if (cand < ENABLE_BITS && enable_mask[cand])
						found = 1;
				end
				if (found)
					sched_idx = cand[3:0];
				else
					r.none = 1'b1;
				r.sensor = sched_idx;
			end
			REQ_PING: begin
				active_idx = sched_idx;
				r.sensor = active_idx;
				q = active_idx / SENSORS_PER_MUX;
				r.branch = q[0];
				q = active_idx % SENSORS_PER_MUX;
				r.channel = q[2:0];
			end
			REQ_ECHO: begin
				s = int'(active_idx);
				if (pw <= echo_min || pw >= echo_max) begin
					if (reject_count[s] != COUNT_SAT)
						reject_count[s]++;
					if (reject_count[s] > invalid_hold) begin
						clear_filter(s);
						r.cleared = 1'b1;
					end
				end else begin
					reject_count[s] = '0;
					slot = int'(ring_head[s]);
					if (slot >= HIST_DEPTH)
						slot = 0;
					ring[s][slot] = pw;
					slot = (slot + 1) % 3;
					ring_head[s] = slot[1:0];
					if (ring_count[s] != HIST_DEPTH)
						ring_count[s]++;
					if (ring_count[s] == 2'd1) begin
						filt_width[s] = ring[s][0];
					end else if (ring_count[s] == 2'd2) begin
						pair_sum = 17'(ring[s][0]) + 17'(ring[s][1]);
						filt_width[s] = pair_sum[16:1];
					end else begin
						filt_width[s] = median3(ring[s][0], ring[s][1], ring[s][2]);
					end
					r.valid = 1'b1;
				end
			end
			default: ;
		endcase
		r.width = filt_width[r.sensor];
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		int           s;
		echo_result_t want;
		if (!arst_n) begin
			echo_min = ECHO_MIN_RST;
			echo_max = ECHO_MAX_RST;
			invalid_hold = INVALID_HOLD_RST;
			enable_mask = ENABLE_MASK_RST;
			sched_idx = '0;
			active_idx = '0;
			for (s = 0; s < NUM_SENSORS; s++) begin
				clear_filter(s);
				reject_count[s] = '0;
			end
			expected_results.delete();
		end else begin
			// result beat of an earlier request can share an edge with a new request
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no request outstanding");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("sensor_index", 32'(want.sensor), 32'(sensor_index));
					check_field("mux_branch", 32'(want.branch), 32'(mux_branch));
					check_field("mux_channel", 32'(want.channel), 32'(mux_channel));
					check_field("filtered_width", 32'(want.width), 32'(filtered_width));
					check_field("sample_valid", 32'(want.valid), 32'(sample_valid));
					check_field("filter_reset", 32'(want.cleared), 32'(filter_reset));
					check_field("none_enabled", 32'(want.none), 32'(none_enabled));
				end
			end
			if (wr_en) begin
				case (wr_index)
					REG_ECHO_MIN:     echo_min = wr_data;
					REG_ECHO_MAX:     echo_max = wr_data;
					REG_INVALID_HOLD: invalid_hold = wr_data[7:0];
					REG_ENABLE_MASK:  enable_mask = wr_data[9:0];
				endcase
			end
			if (start && !busy)
				expected_results.push_back(predict_response(req_type, pulse_width));
		end
		outstanding = expected_results.size();
	end

endmodule

// File: verif/ultrasonic_echo_scheduler_filter_core_test.sv
`timescale 1ns / 100ps
// stimulus and verdict for ultrasonic_echo_scheduler_filter_core; prediction and
// comparison live in ultrasonic_echo_scheduler_filter_checker
// depends on uesf_pkg, the core and the checker module
module ultrasonic_echo_scheduler_filter_core_test;
	import uesf_pkg::*;

	localparam logic [1:0] REQ_UNUSED   = 2'd3;
	localparam int         CYCLE_LIMIT  = 300000;
	localparam int         DRAIN_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  req_type = REQ_ADVANCE;
	logic [15:0] pulse_width = '0;
	logic        wr_en = 1'b0;
	logic [1:0]  wr_index = REG_ECHO_MIN;
	logic [15:0] wr_data = '0;

	wire logic        busy;
	wire logic        done;
	wire logic [3:0]  sensor_index;
	wire logic        mux_branch;
	wire logic [2:0]  mux_channel;
	wire logic [15:0] filtered_width;
	wire logic        sample_valid;
	wire logic        filter_reset;
	wire logic        none_enabled;

	int fail_count;
	int outstanding;
	int cycle_count = 0;
	int idle_pct = 0;
	int cfg_min = int'(ECHO_MIN_RST);
	int cfg_max = int'(ECHO_MAX_RST);

	always #5 clk = ~clk;

	ultrasonic_echo_scheduler_filter_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.pulse_width    (pulse_width),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.done           (done),
		.sensor_index   (sensor_index),
		.mux_branch     (mux_branch),
		.mux_channel    (mux_channel),
		.filtered_width (filtered_width),
		.sample_valid   (sample_valid),
		.filter_reset   (filter_reset),
		.none_enabled   (none_enabled)
	);

	ultrasonic_echo_scheduler_filter_checker echo_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.pulse_width    (pulse_width),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.done           (done),
		.sensor_index   (sensor_index),
		.mux_branch     (mux_branch),
		.mux_channel    (mux_channel),
		.filtered_width (filtered_width),
		.sample_valid   (sample_valid),
		.filter_reset   (filter_reset),
		.none_enabled   (none_enabled),
		.fail_count     (fail_count),
		.outstanding    (outstanding)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ultrasonic_echo_scheduler_filter_core_test: FAIL");
			$finish;
		end
	end

	// busy only moves at the rising edge, so its value here decides the next edge
	task automatic send(logic [1:0] req, logic [15:0] pw);
		bit taken;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			req_type <= 2'($urandom_range(3));
			pulse_width <= 16'($urandom_range(65535));
			@(negedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		pulse_width <= pw;
		do begin
			taken = !busy;
			@(negedge clk);
		end while (!taken);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic configure(int lo_w, int hi_w, int hold, int mask);
		cfg_min = lo_w;
		cfg_max = hi_w;
		wr_en <= 1'b1;
		wr_index <= REG_ECHO_MIN;
		wr_data <= lo_w[15:0];
		@(negedge clk);
		wr_index <= REG_ECHO_MAX;
		wr_data <= hi_w[15:0];
		@(negedge clk);
		wr_index <= REG_INVALID_HOLD;
		wr_data <= hold[15:0];
		@(negedge clk);
		wr_index <= REG_ENABLE_MASK;
		wr_data <= mask[15:0];
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	function automatic logic [15:0] pick_width();
		int lo;
		int hi;
		int w;
		lo = cfg_min + 1;
		hi = cfg_max - 1;
		case ($urandom_range(9))
			0: w = cfg_min;
			1: w = cfg_max;
			2: w = lo;
			3: w = hi;
			4, 5: w = $urandom_range(65535);
			default: w = (hi >= lo) ? $urandom_range(hi, lo) : $urandom_range(65535);
		endcase
		return w[15:0];
	endfunction

	// mostly advance / ping / echo bursts, some stray requests of any kind
	task automatic run_traffic(int n);
		int sent;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(99) < 15) begin
				send(2'($urandom_range(3)), 16'($urandom_range(65535)));
				sent++;
			end else begin
				repeat ($urandom_range(2, 1)) begin
					send(REQ_ADVANCE, 16'($urandom_range(65535)));
					sent++;
				end
				send(REQ_PING, 16'($urandom_range(65535)));
				sent++;
				repeat ($urandom_range(6, 1)) begin
					send(REQ_ECHO, pick_width());
					sent++;
				end
			end
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset configuration, sensor 0 active
		send(REQ_ECHO, 16'd151);
		send(REQ_ECHO, 16'd29999);
		send(REQ_ECHO, 16'd5000);
		send(REQ_ECHO, 16'd20000);
		send(REQ_ECHO, 16'd150);
		send(REQ_ECHO, 16'd30000);
		send(REQ_ECHO, 16'd0);
		send(REQ_ECHO, 16'hffff);
		send(REQ_UNUSED, 16'h5a5a);
		send(REQ_ADVANCE, 16'd0);
		send(REQ_PING, 16'd0);
		send(REQ_ECHO, 16'd29999);
		send(REQ_ECHO, 16'd151);
		repeat (8) send(REQ_ADVANCE, 16'hffff);
		send(REQ_PING, 16'hffff);
		send(REQ_ECHO, 16'd1234);
		send(REQ_ADVANCE, 16'd0);
		send(REQ_PING, 16'd0);
		drain();

		configure(0, 65535, 0, 'h3ff);
		idle_pct = 66;
		run_traffic(20);
		drain();

		configure(1000, 1200, 2, 'h2a5);
		idle_pct = 29;
		run_traffic(20);
		drain();

		// nothing valid and nothing scheduled
		configure(65535, 1, 255, 0);
		idle_pct = 0;
		run_traffic(20);
		drain();

		configure(150, 30000, 5, $urandom_range(1023));
		idle_pct = 66;
		run_traffic(20);
		drain();

		configure($urandom_range(20000), $urandom_range(65535, 1), $urandom_range(255),
			$urandom_range(1023));
		idle_pct = 29;
		run_traffic(20);
		drain();

		// push one sensor's reject counter into saturation, then drop the hold below it
		configure(65535, 1, 255, 'h3ff);
		send(REQ_ADVANCE, 16'd0);
		send(REQ_PING, 16'd0);
		repeat (270) send(REQ_ECHO, 16'($urandom_range(65535)));
		drain();
		configure(65535, 1, 254, 'h155);
		idle_pct = 0;
		send(REQ_ECHO, 16'($urandom_range(65535)));
		send(REQ_ECHO, 16'($urandom_range(65535)));
		drain();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("ultrasonic_echo_scheduler_filter_core_test: PASS");
		else
			$display("ultrasonic_echo_scheduler_filter_core_test: FAIL");
		$finish;
	end

endmodule

// File: files.f
rtl/uesf_pkg.sv
rtl/ultrasonic_echo_scheduler_filter_core.sv
rtl/uesf_checker.sv
verif/ultrasonic_echo_scheduler_filter_checker.sv
verif/ultrasonic_echo_scheduler_filter_core_test.sv
